// ===== hw/rtl/pva_pkg.sv =====
// shared opcodes, status codes and constants of the voice allocator
`timescale 1ns / 1ps

package pva_pkg;

    typedef enum logic [2:0] {
        OP_NOTE_ON  = 3'd0,
        OP_NOTE_OFF = 3'd1,
        OP_TICK     = 3'd2,
        OP_ENV_DONE = 3'd3,
        OP_ALL_OFF  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_ASSIGNED = 2'd1,
        ST_RELEASED = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_FADE_SAMPLES = 2'd0,
        REG_GLIDE_ENABLE = 2'd1,
        REG_RETRIGGER    = 2'd2
    } reg_index_t;

    localparam logic [7:0]  NOTE_NONE    = 8'h80;
    localparam logic [15:0] FADE_RESET   = 16'd240;
    localparam int          ADDR_W       = 4;

endpackage

// ===== hw/rtl/polyphonic_voice_allocator_unit.sv =====
// polyphonic voice slot allocator with oldest-note stealing
//
// Input channel s_*: one item carries an opcode (note on, note off, sample
// tick, envelope finished, all notes off) with note, velocity and slot_select.
// Result channel m_*: exactly one result item per input item, giving status,
// the slot assigned or released, any steal victim, envelope trigger, glide,
// the stored note and velocity, and the count of sounding slots.
// Configuration goes through the APB port: fade_samples at 0x0,
// glide_enable at 0x4, retrigger_always at 0x8; pready is always high.
// Each item is handled by a small sequencer over one slot per cycle:
// note on / note off: accept, scan over all VOICES slots, update, count pass
// over all slots, finish; sample tick: accept, tick pass, count pass, finish;
// envelope finished, all notes off: accept, update, count pass, finish;
// unused opcodes: accept, count pass, finish. s_ready is high only while
// idle; one item is in work at a time.
// A finished result sits in the output register; the next item is accepted
// meanwhile, and if it finishes before m_ready takes the previous one, the
// sequencer holds in its last step until the output register is free.
// aresetn (synchronous, active low) frees every slot, clears the order stamp
// counter and loads the register reset values.
`timescale 1ns / 1ps

module polyphonic_voice_allocator_unit #(
    parameter int VOICES = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pva_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // input items
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_opcode,
    input  logic [6:0]                 s_note,
    input  logic [6:0]                 s_velocity,
    input  logic [3:0]                 s_slot_select,
    // result items
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [3:0]                 m_slot,
    output logic                       m_victim_valid,
    output logic [3:0]                 m_victim_slot,
    output logic                       m_env_trigger,
    output logic                       m_glide,
    output logic [6:0]                 m_out_note,
    output logic [6:0]                 m_out_velocity,
    output logic [4:0]                 m_active_count
);

    localparam int SW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(VOICES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TICK,
        S_APPLY,
        S_COUNT,
        S_FINISH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [15:0] fade_samples_reg;
    logic        glide_enable_reg;
    logic        retrigger_reg;

    // slot state
    logic [7:0]  slot_note_reg     [VOICES];
    logic        key_down_reg      [VOICES];
    logic        slot_active_reg   [VOICES];
    logic [31:0] start_order_reg   [VOICES];
    logic [15:0] fade_left_reg     [VOICES];
    logic [6:0]  slot_velocity_reg [VOICES];
    logic [31:0] order_counter_reg;

    // latched item
    logic [2:0]  op_reg;
    logic [6:0]  note_reg;
    logic [6:0]  vel_reg;
    logic [3:0]  sel_reg;

    // sequencer
    logic [SW-1:0] idx_reg;
    logic          note_found_reg;
    logic [SW-1:0] note_idx_reg;
    logic          free_found_reg;
    logic [SW-1:0] free_idx_reg;
    logic          rel_found_reg;
    logic [SW-1:0] rel_idx_reg;
    logic [31:0]   rel_so_reg;
    logic          any_found_reg;
    logic [SW-1:0] any_idx_reg;
    logic [31:0]   any_so_reg;
    logic [CW-1:0] cnt_reg;

    // result being built
    logic [1:0]  res_status_reg;
    logic [3:0]  res_slot_reg;
    logic        res_vvalid_reg;
    logic [3:0]  res_vslot_reg;
    logic        res_trig_reg;
    logic        res_glide_reg;
    logic [6:0]  res_note_reg;
    logic [6:0]  res_vel_reg;

    // output register
    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [3:0]  m_slot_reg;
    logic        m_vvalid_reg;
    logic [3:0]  m_vslot_reg;
    logic        m_trig_reg;
    logic        m_glide_reg;
    logic [6:0]  m_note_reg;
    logic [6:0]  m_vel_reg;
    logic [4:0]  m_count_reg;

    // decode of the slot under the scan pointer
    logic        cur_live;
    logic        cur_fz;
    logic [31:0] cur_so;
    logic [15:0] cur_fade_dec;
    logic        rel_better;
    logic        any_better;

    // note-on decision
    logic          have_victim;
    logic [SW-1:0] victim_idx;
    logic          sel_in_range;
    logic [SW-1:0] sel_idx;
    logic          cfg_write;

    always_comb begin
        cur_live     = key_down_reg[idx_reg] | slot_active_reg[idx_reg];
        cur_fz       = (fade_left_reg[idx_reg] == 16'd0);
        cur_so       = start_order_reg[idx_reg];
        cur_fade_dec = fade_left_reg[idx_reg] - 16'd1;
        rel_better   = !rel_found_reg || (cur_so < rel_so_reg);
        any_better   = !any_found_reg || (cur_so < any_so_reg);
        have_victim  = rel_found_reg | any_found_reg;
        victim_idx   = rel_found_reg ? rel_idx_reg : any_idx_reg;
        sel_in_range = ({3'd0, sel_reg} < 7'(VOICES));
        sel_idx      = SW'(sel_reg);
        cfg_write    = psel & penable & pwrite;
    end

    always_comb begin
        unique case (paddr[3:2])
            pva_pkg::REG_FADE_SAMPLES: prdata = {16'd0, fade_samples_reg};
            pva_pkg::REG_GLIDE_ENABLE: prdata = {31'd0, glide_enable_reg};
            pva_pkg::REG_RETRIGGER:    prdata = {31'd0, retrigger_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign pready  = 1'b1;
    assign s_ready = aresetn && (state_reg == S_IDLE);

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot         = m_slot_reg;
    assign m_victim_valid = m_vvalid_reg;
    assign m_victim_slot  = m_vslot_reg;
    assign m_env_trigger  = m_trig_reg;
    assign m_glide        = m_glide_reg;
    assign m_out_note     = m_note_reg;
    assign m_out_velocity = m_vel_reg;
    assign m_active_count = m_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            fade_samples_reg  <= pva_pkg::FADE_RESET;
            glide_enable_reg  <= 1'b0;
            retrigger_reg     <= 1'b0;
            order_counter_reg <= 32'd0;
            m_valid_reg       <= 1'b0;
            idx_reg           <= '0;
            for (int i = 0; i < VOICES; i++) begin
                slot_note_reg[i]     <= pva_pkg::NOTE_NONE;
                key_down_reg[i]      <= 1'b0;
                slot_active_reg[i]   <= 1'b0;
                start_order_reg[i]   <= 32'd0;
                fade_left_reg[i]     <= 16'd0;
                slot_velocity_reg[i] <= 7'd0;
            end
        end else begin
            if (cfg_write) begin
                unique case (paddr[3:2])
                    pva_pkg::REG_FADE_SAMPLES: fade_samples_reg <= pwdata[15:0];
                    pva_pkg::REG_GLIDE_ENABLE: glide_enable_reg <= pwdata[0];
                    pva_pkg::REG_RETRIGGER:    retrigger_reg    <= pwdata[0];
                    default: ;
                endcase
            end

            // in the finish step the output register is reloaded instead
            if (m_valid_reg && m_ready && state_reg != S_FINISH) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg         <= s_opcode;
                        note_reg       <= s_note;
                        vel_reg        <= s_velocity;
                        sel_reg        <= s_slot_select;
                        idx_reg        <= '0;
                        cnt_reg        <= '0;
                        note_found_reg <= 1'b0;
                        free_found_reg <= 1'b0;
                        rel_found_reg  <= 1'b0;
                        any_found_reg  <= 1'b0;
                        res_status_reg <= pva_pkg::ST_NONE;
                        res_slot_reg   <= 4'd0;
                        res_vvalid_reg <= 1'b0;
                        res_vslot_reg  <= 4'd0;
                        res_trig_reg   <= 1'b0;
                        res_glide_reg  <= 1'b0;
                        res_note_reg   <= 7'd0;
                        res_vel_reg    <= 7'd0;
                        unique case (s_opcode)
                            pva_pkg::OP_NOTE_ON,
                            pva_pkg::OP_NOTE_OFF: state_reg <= S_SCAN;
                            pva_pkg::OP_TICK:     state_reg <= S_TICK;
                            pva_pkg::OP_ENV_DONE,
                            pva_pkg::OP_ALL_OFF:  state_reg <= S_APPLY;
                            default:              state_reg <= S_COUNT;
                        endcase
                    end
                end

                S_SCAN: begin
                    // first matching note, first free slot, oldest released, oldest live
                    if (!note_found_reg && cur_live && cur_fz
                            && slot_note_reg[idx_reg] == {1'b0, note_reg}) begin
                        note_found_reg <= 1'b1;
                        note_idx_reg   <= idx_reg;
                    end
                    if (!free_found_reg && !cur_live && cur_fz) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= idx_reg;
                    end
                    if (cur_fz && cur_live && !key_down_reg[idx_reg] && rel_better) begin
                        rel_found_reg <= 1'b1;
                        rel_idx_reg   <= idx_reg;
                        rel_so_reg    <= cur_so;
                    end
                    if (cur_fz && cur_live && any_better) begin
                        any_found_reg <= 1'b1;
                        any_idx_reg   <= idx_reg;
                        any_so_reg    <= cur_so;
                    end
                    if (idx_reg == LAST_SLOT) begin
                        idx_reg   <= '0;
                        state_reg <= S_APPLY;
                    end else begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end

                S_TICK: begin
                    if (cur_live && !cur_fz) begin
                        fade_left_reg[idx_reg] <= cur_fade_dec;
                        if (cur_fade_dec == 16'd0) begin
                            slot_active_reg[idx_reg] <= 1'b0;
                            key_down_reg[idx_reg]    <= 1'b0;
                            slot_note_reg[idx_reg]   <= pva_pkg::NOTE_NONE;
                        end
                    end
                    if (idx_reg == LAST_SLOT) begin
                        idx_reg   <= '0;
                        state_reg <= S_COUNT;
                    end else begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end

                S_APPLY: begin
                    state_reg <= S_COUNT;
                    idx_reg   <= '0;
                    unique case (op_reg)
                        pva_pkg::OP_NOTE_ON: begin
                            if (note_found_reg || free_found_reg || have_victim) begin
                                logic [SW-1:0] v;
                                v = note_found_reg ? note_idx_reg
                                  : free_found_reg ? free_idx_reg : victim_idx;
                                if (!note_found_reg && !free_found_reg) begin
                                    // stolen slot starts fading and takes the new note
                                    fade_left_reg[v] <= (fade_samples_reg == 16'd0)
                                                      ? 16'd1 : fade_samples_reg;
                                    res_vvalid_reg   <= 1'b1;
                                    res_vslot_reg    <= 4'(v);
                                end
                                slot_note_reg[v]     <= {1'b0, note_reg};
                                key_down_reg[v]      <= 1'b1;
                                slot_active_reg[v]   <= 1'b1;
                                start_order_reg[v]   <= order_counter_reg;
                                slot_velocity_reg[v] <= vel_reg;
                                order_counter_reg    <= order_counter_reg + 32'd1;
                                res_status_reg       <= pva_pkg::ST_ASSIGNED;
                                res_slot_reg         <= 4'(v);
                                res_trig_reg         <= !note_found_reg || retrigger_reg;
                                res_glide_reg        <= glide_enable_reg && note_found_reg;
                                res_note_reg         <= note_reg;
                                res_vel_reg          <= vel_reg;
                            end else begin
                                res_status_reg <= pva_pkg::ST_NOT_FOUND;
                            end
                        end
                        pva_pkg::OP_NOTE_OFF: begin
                            if (note_found_reg) begin
                                key_down_reg[note_idx_reg] <= 1'b0;
                                res_status_reg <= pva_pkg::ST_RELEASED;
                                res_slot_reg   <= 4'(note_idx_reg);
                            end else begin
                                res_status_reg <= pva_pkg::ST_NOT_FOUND;
                            end
                        end
                        pva_pkg::OP_ENV_DONE: begin
                            if (sel_in_range && !key_down_reg[sel_idx]) begin
                                slot_active_reg[sel_idx] <= 1'b0;
                            end
                        end
                        pva_pkg::OP_ALL_OFF: begin
                            for (int i = 0; i < VOICES; i++) begin
                                key_down_reg[i] <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end

                S_COUNT: begin
                    if (cur_live && !slot_note_reg[idx_reg][7]) begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (idx_reg == LAST_SLOT) begin
                        idx_reg   <= '0;
                        state_reg <= S_FINISH;
                    end else begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end

                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_slot_reg   <= res_slot_reg;
                        m_vvalid_reg <= res_vvalid_reg;
                        m_vslot_reg  <= res_vslot_reg;
                        m_trig_reg   <= res_trig_reg;
                        m_glide_reg  <= res_glide_reg;
                        m_note_reg   <= res_note_reg;
                        m_vel_reg    <= res_vel_reg;
                        m_count_reg  <= 5'(cnt_reg);
                        state_reg    <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the polyphonic voice allocator
`timescale 1ns / 1ps

module tb;

    localparam int VOICES          = 16;
    localparam int QUIET_LIMIT     = 2000;
    localparam int PHASES          = 6;
    localparam int RANDOM_PHASE    = 2;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int TAIL_CYCLES     = 40;
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0] opcode;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [3:0] slot_select;
    } voice_event_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
        logic       victim_valid;
        logic [3:0] victim_slot;
        logic       env_trigger;
        logic       glide;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [4:0] active_count;
    } voice_result_t;

    typedef struct packed {
        voice_event_t  ev;
        logic          typed;
        voice_result_t res;
    } stim_row_t;

    localparam voice_result_t NO_RES = '0;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [pva_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode = '0;
    logic [6:0]  s_note = '0;
    logic [6:0]  s_velocity = '0;
    logic [3:0]  s_slot_select = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [3:0]  m_slot;
    logic        m_victim_valid;
    logic [3:0]  m_victim_slot;
    logic        m_env_trigger;
    logic        m_glide;
    logic [6:0]  m_out_note;
    logic [6:0]  m_out_velocity;
    logic [4:0]  m_active_count;

    // shadow of the slot state and registers
    logic [7:0]  note_q [VOICES];
    bit          key_q [VOICES];
    bit          act_q [VOICES];
    logic [31:0] stamp_q [VOICES];
    logic [15:0] fade_q [VOICES];
    logic [31:0] stamp_next;
    logic [15:0] cfg_fade;
    bit          cfg_glide;
    bit          cfg_retrig;

    voice_result_t due_outcomes [$];
    int          fails = 0;
    int          result_no = 0;
    int          quiet_cycles = 0;
    bit          steady = 1'b0;

    int phase_fade [PHASES]   = '{1, 3, 0, 0, 240, 65535};
    int phase_glide [PHASES]  = '{1, 0, 0, 1, 0, 1};
    int phase_retrig [PHASES] = '{0, 1, 0, 1, 0, 1};

    // runs with fade_samples = 0, glide and retrigger off
    stim_row_t dir_rows [25] = '{
        '{'{pva_pkg::OP_NOTE_OFF, 7'd60, 7'd0, 4'd0}, 1'b1,
          '{pva_pkg::ST_NOT_FOUND, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 7'd0, 7'd0, 5'd0}},
        '{'{OP_UNUSED_HI, 7'd0, 7'd0, 4'd0}, 1'b1,
          '{pva_pkg::ST_NONE, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 7'd0, 7'd0, 5'd0}},
        '{'{pva_pkg::OP_NOTE_ON, 7'd0, 7'd0, 4'd0}, 1'b1,
          '{pva_pkg::ST_ASSIGNED, 4'd0, 1'b0, 4'd0, 1'b1, 1'b0, 7'd0, 7'd0, 5'd1}},
        '{'{pva_pkg::OP_NOTE_ON, 7'd127, 7'd127, 4'd15}, 1'b1,
          '{pva_pkg::ST_ASSIGNED, 4'd1, 1'b0, 4'd0, 1'b1, 1'b0, 7'd127, 7'd127, 5'd2}},
        // same note again: reused without retrigger
        '{'{pva_pkg::OP_NOTE_ON, 7'd127, 7'd64, 4'd0}, 1'b1,
          '{pva_pkg::ST_ASSIGNED, 4'd1, 1'b0, 4'd0, 1'b0, 1'b0, 7'd127, 7'd64, 5'd2}},
        '{'{pva_pkg::OP_NOTE_OFF, 7'd127, 7'd0, 4'd0}, 1'b1,
          '{pva_pkg::ST_RELEASED, 4'd1, 1'b0, 4'd0, 1'b0, 1'b0, 7'd0, 7'd0, 5'd2}},
        // fill slots 2..15
        '{'{pva_pkg::OP_NOTE_ON, 7'd1, 7'd90, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd2, 7'd85, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd3, 7'd42, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd4, 7'd21, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd5, 7'd10, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd6, 7'd1, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd7, 7'd126, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd8, 7'd100, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd9, 7'd77, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd10, 7'd55, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd11, 7'd33, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd12, 7'd12, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd13, 7'd64, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd14, 7'd96, 4'd0}, 1'b0, NO_RES},
        // full: steal the released slot, then the oldest held one
        '{'{pva_pkg::OP_NOTE_ON, 7'd100, 7'd100, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_NOTE_ON, 7'd101, 7'd33, 4'd0}, 1'b0, NO_RES},
        // release then finish the envelope of a fading slot: it stays reserved
        '{'{pva_pkg::OP_ALL_OFF, 7'd0, 7'd0, 4'd0}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_ENV_DONE, 7'd0, 7'd0, 4'd1}, 1'b0, NO_RES},
        '{'{pva_pkg::OP_TICK, 7'd0, 7'd0, 4'd0}, 1'b0, NO_RES}
    };

    polyphonic_voice_allocator_unit dut (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) m_ready <= steady || ($urandom_range(99) >= 22);

    function automatic bit sounding(int s);
        return key_q[s] || act_q[s];
    endfunction

    function automatic int slot_with_note(logic [6:0] n);
        for (int s = 0; s < VOICES; s++)
            if (sounding(s) && note_q[s] == {1'b0, n} && fade_q[s] == 0)
                return s;
        return -1;
    endfunction

    function automatic int first_free_slot();
        for (int s = 0; s < VOICES; s++)
            if (!sounding(s) && fade_q[s] == 0)
                return s;
        return -1;
    endfunction

    // oldest released slot first, else oldest held; fading slots are skipped
    function automatic int steal_choice();
        int best;
        best = -1;
        for (int s = 0; s < VOICES; s++)
            if (fade_q[s] == 0 && sounding(s) && !key_q[s])
                if (best < 0 || stamp_q[s] < stamp_q[best])
                    best = s;
        if (best >= 0)
            return best;
        for (int s = 0; s < VOICES; s++)
            if (fade_q[s] == 0 && sounding(s))
                if (best < 0 || stamp_q[s] < stamp_q[best])
                    best = s;
        return best;
    endfunction

    function automatic logic [4:0] notes_sounding();
        logic [4:0] n;
        n = '0;
        for (int s = 0; s < VOICES; s++)
            if (sounding(s) && !note_q[s][7])
                n = n + 1'b1;
        return n;
    endfunction

    // applies one item to the shadow state and returns the result it causes
    function automatic voice_result_t voice_update(voice_event_t ev);
        voice_result_t r;
        int v;
        int victim;
        bit was;
        r = '0;
        victim = -1;
        case (ev.opcode)
            pva_pkg::OP_NOTE_ON: begin
                v = slot_with_note(ev.note);
                if (v < 0)
                    v = first_free_slot();
                if (v < 0) begin
                    victim = steal_choice();
                    if (victim >= 0) begin
                        fade_q[victim] = (cfg_fade == 0) ? 16'd1 : cfg_fade;
                        note_q[victim] = pva_pkg::NOTE_NONE;
                        key_q[victim] = 1'b0;
                        v = first_free_slot();
                        if (v < 0)
                            v = victim;
                    end
                end
                if (v < 0) begin
                    r.status = pva_pkg::ST_NOT_FOUND;
                end else begin
                    was = sounding(v) && fade_q[v] == 0;
                    note_q[v] = {1'b0, ev.note};
                    key_q[v] = 1'b1;
                    act_q[v] = 1'b1;
                    stamp_q[v] = stamp_next;
                    stamp_next = stamp_next + 32'd1;
                    r.status = pva_pkg::ST_ASSIGNED;
                    r.slot = 4'(v);
                    if (victim >= 0) begin
                        r.victim_valid = 1'b1;
                        r.victim_slot = 4'(victim);
                    end
                    r.env_trigger = !was || cfg_retrig;
                    r.glide = cfg_glide && was;
                    r.note = ev.note;
                    r.velocity = ev.velocity;
                end
            end
            pva_pkg::OP_NOTE_OFF: begin
                v = slot_with_note(ev.note);
                if (v < 0) begin
                    r.status = pva_pkg::ST_NOT_FOUND;
                end else begin
                    key_q[v] = 1'b0;
                    r.status = pva_pkg::ST_RELEASED;
                    r.slot = 4'(v);
                end
            end
            pva_pkg::OP_TICK: begin
                for (int s = 0; s < VOICES; s++) begin
                    if (sounding(s) && fade_q[s] != 0) begin
                        fade_q[s] = fade_q[s] - 1'b1;
                        if (fade_q[s] == 0) begin
                            act_q[s] = 1'b0;
                            key_q[s] = 1'b0;
                            note_q[s] = pva_pkg::NOTE_NONE;
                        end
                    end
                end
            end
            pva_pkg::OP_ENV_DONE: begin
                if (!key_q[ev.slot_select])
                    act_q[ev.slot_select] = 1'b0;
            end
            pva_pkg::OP_ALL_OFF: begin
                for (int s = 0; s < VOICES; s++)
                    key_q[s] = 1'b0;
            end
            default: ;
        endcase
        r.active_count = notes_sounding();
        return r;
    endfunction

    // mostly musical traffic: a narrow note range, note-offs of held notes and
    // envelope ends of released slots, with some noise mixed in
    function automatic voice_event_t random_event();
        voice_event_t ev;
        int pick;
        int cands [$];
        pick = $urandom_range(99);
        ev.note = ($urandom_range(99) < 75) ? 7'($urandom_range(59, 40))
                                            : 7'($urandom_range(127));
        ev.velocity = 7'($urandom_range(127));
        ev.slot_select = 4'($urandom_range(15));
        if (pick < 45) begin
            ev.opcode = pva_pkg::OP_NOTE_ON;
        end else if (pick < 70) begin
            ev.opcode = pva_pkg::OP_NOTE_OFF;
            for (int s = 0; s < VOICES; s++)
                if (sounding(s) && fade_q[s] == 0 && !note_q[s][7])
                    cands = {cands, s};
            if (cands.size() > 0 && $urandom_range(99) < 70)
                ev.note = note_q[cands[$urandom_range(cands.size() - 1)]][6:0];
        end else if (pick < 85) begin
            ev.opcode = pva_pkg::OP_TICK;
        end else if (pick < 95) begin
            ev.opcode = pva_pkg::OP_ENV_DONE;
            for (int s = 0; s < VOICES; s++)
                if (!key_q[s] && act_q[s] && fade_q[s] == 0)
                    cands = {cands, s};
            if (cands.size() > 0 && $urandom_range(99) < 85)
                ev.slot_select = 4'(cands[$urandom_range(cands.size() - 1)]);
        end else if (pick < 98) begin
            ev.opcode = pva_pkg::OP_ALL_OFF;
        end else begin
            ev.opcode = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        end
        return ev;
    endfunction

    task automatic send_event(voice_event_t ev, logic typed, voice_result_t typed_res);
        voice_result_t r;
        if (!steady && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(45, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= ev.opcode;
        s_note <= ev.note;
        s_velocity <= ev.velocity;
        s_slot_select <= ev.slot_select;
        do @(posedge aclk); while (s_ready !== 1'b1);
        r = voice_update(ev);
        if (typed)
            r = typed_res;
        due_outcomes = {due_outcomes, r};
    endtask

    task automatic write_reg(pva_pkg::reg_index_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        case (idx)
            pva_pkg::REG_FADE_SAMPLES: cfg_fade = value[15:0];
            pva_pkg::REG_GLIDE_ENABLE: cfg_glide = value[0];
            pva_pkg::REG_RETRIGGER:    cfg_retrig = value[0];
            default: ;
        endcase
    endtask

    // upper bits carry junk that the block must drop
    task automatic load_config(int fade, int glide, int retrig);
        write_reg(pva_pkg::REG_FADE_SAMPLES, {16'($urandom), 16'(fade)});
        write_reg(pva_pkg::REG_GLIDE_ENABLE, {31'($urandom), 1'(glide)});
        write_reg(pva_pkg::REG_RETRIGGER, {31'($urandom), 1'(retrig)});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (due_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: result %0d %s expected %0d, got %0d",
                     $time, result_no, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        voice_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (due_outcomes.size() == 0) begin
                fails++;
                $display("%0t: result with nothing expected, got status %0d slot %0d",
                         $time, m_status, m_slot);
            end else begin
                want = due_outcomes.pop_front();
                check_field("status", want.status, m_status);
                check_field("slot", want.slot, m_slot);
                check_field("victim_valid", want.victim_valid, m_victim_valid);
                check_field("victim_slot", want.victim_slot, m_victim_slot);
                check_field("env_trigger", want.env_trigger, m_env_trigger);
                check_field("glide", want.glide, m_glide);
                check_field("out_note", want.note, m_out_note);
                check_field("out_velocity", want.velocity, m_out_velocity);
                check_field("active_count", want.active_count, m_active_count);
            end
            result_no++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        for (int s = 0; s < VOICES; s++) begin
            note_q[s] = pva_pkg::NOTE_NONE;
            key_q[s] = 1'b0;
            act_q[s] = 1'b0;
            stamp_q[s] = '0;
            fade_q[s] = '0;
        end
        stamp_next = '0;
        cfg_fade = pva_pkg::FADE_RESET;
        cfg_glide = 1'b0;
        cfg_retrig = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // zero fade length behaves as one
        load_config(0, 0, 0);
        foreach (dir_rows[i])
            send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].res);
        for (int p = 0; p < PHASES; p++) begin
            // sender holds off until every result is back, then reconfigures
            wait_drained();
            if (p == RANDOM_PHASE)
                load_config($urandom_range(12, 2), $urandom_range(1), $urandom_range(1));
            else
                load_config(phase_fade[p], phase_glide[p], phase_retrig[p]);
            steady = (p == RANDOM_PHASE);
            repeat (ITEMS_PER_PHASE)
                send_event(random_event(), 1'b0, NO_RES);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fails == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
